@@ rtl/gfel_pkg.sv @@
// ----------------------------------------------------------------------------
// gfel_pkg
// Shared types and constants for the GF(2^m) antilog/log table engine.
// ----------------------------------------------------------------------------
package gfel_pkg;

	localparam int MAX_DEGREE_DEF = 8;

	localparam int OP_W     = 2;
	localparam int EXP_W    = 16;
	localparam int ELEM_W   = 8;
	localparam int LOG_W    = 9;
	localparam int STATUS_W = 2;
	localparam int DEG_W    = 4;
	localparam int POLY_W   = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [DEG_W-1:0]  DEGREE_RESET = 4'd8;
	localparam logic [POLY_W-1:0] POLY_RESET   = 8'd29;

	localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_POLY   = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_PRIMITIVE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_STEP_RANGE    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_BUILT     = 2'd3;

	// log of the zero element
	localparam logic [LOG_W-1:0] LOG_ZERO = 9'h1FF;

	typedef enum logic [OP_W-1:0] {
		OP_BUILD   = 2'd0,
		OP_ANTILOG = 2'd1,
		OP_LOG     = 2'd2,
		OP_POWER   = 2'd3
	} op_t;

	typedef struct packed {
		logic capture;
		logic build_step;
		logic mul_load;
		logic fold_step;
		logic al_from_fold;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic tables_valid;
		op_t  op;
		logic build_last;
		logic elem_zero;
		logic fold_done;
	} stat_t;

endpackage

@@ rtl/gf2m_exp_log_table_engine.sv @@
// ----------------------------------------------------------------------------
// gf2m_exp_log_table_engine
// GF(2^m) antilog/log table builder and lookup engine.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// shows for one cycle with done high and must be taken then, as the receiver
// cannot stall. A build walks alpha^i one step per cycle through both stores.
// Antilog and log results come from one registered read of the store; an
// item refused as not built goes straight to its result. A power reads the
// log store, registers the product, folds it by the mod (2^m - 1) reduction,
// roughly (MAX_DEGREE+16)/m fold passes at most, then reads the antilog. Any
// register write clears the built flag; the tables must be built again.
module gf2m_exp_log_table_engine #(
	parameter int MAX_DEGREE = gfel_pkg::MAX_DEGREE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gfel_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gfel_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  logic [gfel_pkg::OP_W-1:0]         op,
	input  logic [gfel_pkg::EXP_W-1:0]        exponent,
	input  logic [gfel_pkg::ELEM_W-1:0]       element,
	output logic                              done,
	output logic [gfel_pkg::ELEM_W-1:0]       element_out,
	output logic signed [gfel_pkg::LOG_W-1:0] log_out,
	output logic [gfel_pkg::STATUS_W-1:0]     status
);
	import gfel_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  cfg_we;

	assign cfg_ready = ~busy;
	assign cfg_we    = cfg_valid & cfg_ready;

	gfel_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gfel_dp #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.exponent    (exponent),
		.element     (element),
		.cmd         (cmd),
		.stat        (stat),
		.element_out (element_out),
		.log_out     (log_out),
		.status      (status)
	);

endmodule

@@ rtl/gfel_ctrl.sv @@
// ----------------------------------------------------------------------------
// gfel_ctrl
// Sequencer: steps each item through build, lookup or power phases.
// ----------------------------------------------------------------------------
module gfel_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [gfel_pkg::OP_W-1:0]     op,
	input  gfel_pkg::stat_t               stat,
	output gfel_pkg::cmd_t                cmd,
	output logic                          busy,
	output logic                          done
);
	import gfel_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_BUILD = 6'b000010,
		S_READ  = 6'b000100,
		S_MUL   = 6'b001000,
		S_FOLD  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					if (op_t'(op) == OP_BUILD) begin
						state_d = S_BUILD;
					end else if (!stat.tables_valid) begin
						state_d = S_DONE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_BUILD: begin
				cmd.build_step = 1'b1;
				if (stat.build_last) begin
					state_d = S_DONE;
				end
			end
			S_READ: begin
				if (stat.op == OP_POWER && !stat.elem_zero) begin
					state_d = S_MUL;
				end else begin
					state_d = S_DONE;
				end
			end
			S_MUL: begin
				cmd.mul_load = 1'b1;
				state_d      = S_FOLD;
			end
			S_FOLD: begin
				if (stat.fold_done) begin
					cmd.al_from_fold = 1'b1;
					state_d          = S_DONE;
				end else begin
					cmd.fold_step = 1'b1;
				end
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

@@ rtl/gfel_dp.sv @@
// ----------------------------------------------------------------------------
// gfel_dp
// Datapath: field registers, antilog/log stores, power walk, multiply and
// mod (2^m - 1) fold, result selection.
// ----------------------------------------------------------------------------
module gfel_dp #(
	parameter int MAX_DEGREE = gfel_pkg::MAX_DEGREE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gfel_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gfel_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [gfel_pkg::OP_W-1:0]         op,
	input  logic [gfel_pkg::EXP_W-1:0]        exponent,
	input  logic [gfel_pkg::ELEM_W-1:0]       element,
	input  gfel_pkg::cmd_t                    cmd,
	output gfel_pkg::stat_t                   stat,
	output logic [gfel_pkg::ELEM_W-1:0]       element_out,
	output logic signed [gfel_pkg::LOG_W-1:0] log_out,
	output logic [gfel_pkg::STATUS_W-1:0]     status
);
	import gfel_pkg::*;

	localparam int W     = MAX_DEGREE;
	localparam int DEPTH = 1 << W;
	localparam int DW    = $clog2(MAX_DEGREE + 1);
	localparam int PW    = W + EXP_W;

	logic [DEG_W-1:0]  degree_q;
	logic [POLY_W-1:0] poly_q;
	logic              tables_valid_q;

	op_t             op_q;
	logic [EXP_W-1:0] expo_q;
	logic [W-1:0]    elem_q;
	logic [W-1:0]    cur_q;
	logic [W-1:0]    i_q;
	logic [PW-1:0]   x_q;
	logic [W-1:0]    al_rd_q;
	logic [W-1:0]    lg_rd_q;

	logic [W-1:0] antilog_mem [DEPTH];
	logic [W-1:0] log_mem     [DEPTH];

	logic [DW-1:0] m;
	logic [W-1:0]  mask;
	logic [W-1:0]  poly;
	logic          top_bit;
	logic [W-1:0]  shifted;
	logic [W-1:0]  cur_next;
	logic [W-1:0]  elem_m;
	logic          elem_zero;
	logic [PW-1:0] prod;
	logic [PW-1:0] x_hi;
	logic [PW-1:0] fold_sum;
	logic [W-1:0]  s;
	logic [W-1:0]  al_addr;

	// degree clamped to 2..MAX_DEGREE
	always_comb begin
		if (int'(degree_q) < 2) begin
			m = DW'(2);
		end else if (int'(degree_q) > MAX_DEGREE) begin
			m = DW'(MAX_DEGREE);
		end else begin
			m = DW'(degree_q);
		end
	end

	assign mask     = ~({W{1'b1}} << m);
	assign poly     = W'(poly_q) & mask;
	// x^(m-1) coefficient picked out by the top bit of the mask
	assign top_bit  = |(cur_q & mask & ~(mask >> 1));
	assign shifted  = (cur_q << 1) & mask;
	assign cur_next = top_bit ? (shifted ^ poly) : shifted;

	assign elem_m    = elem_q & mask;
	assign elem_zero = (elem_m == '0);

	assign prod     = {{EXP_W{1'b0}}, lg_rd_q} * {{W{1'b0}}, expo_q};
	// x mod (2^m - 1): fold the high part onto the low m bits
	assign x_hi     = x_q >> m;
	assign fold_sum = (x_q & PW'(mask)) + x_hi;
	assign s        = (x_q[W-1:0] == mask) ? '0 : x_q[W-1:0];
	assign al_addr  = cmd.al_from_fold ? s : expo_q[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q       <= DEGREE_RESET;
			poly_q         <= POLY_RESET;
			tables_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tables_valid_q <= 1'b0;
				case (cfg_index)
					REG_DEGREE: degree_q <= cfg_data[DEG_W-1:0];
					REG_POLY:   poly_q   <= cfg_data;
					default: ;
				endcase
			end else if (cmd.finish && op_q == OP_BUILD) begin
				tables_valid_q <= (cur_q == W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op_t'(op);
			expo_q <= exponent;
			elem_q <= W'(element);
			cur_q  <= W'(1);
			i_q    <= '0;
		end else if (cmd.build_step) begin
			cur_q <= cur_next;
			i_q   <= i_q + W'(1);
		end
		if (cmd.mul_load) begin
			x_q <= prod;
		end else if (cmd.fold_step) begin
			x_q <= fold_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.build_step) begin
			antilog_mem[i_q] <= cur_q;
		end
		al_rd_q <= antilog_mem[al_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.build_step) begin
			log_mem[cur_q] <= i_q;
		end
		lg_rd_q <= log_mem[elem_m];
	end

	always_comb begin
		stat.tables_valid = tables_valid_q;
		stat.op           = op_q;
		stat.build_last   = (i_q == mask - W'(1));
		stat.elem_zero    = elem_zero;
		stat.fold_done    = (x_hi == '0);
	end

	always_comb begin
		element_out = '0;
		log_out     = '0;
		status      = ST_OK;
		if (op_q == OP_BUILD) begin
			status = (cur_q == W'(1)) ? ST_OK : ST_NOT_PRIMITIVE;
		end else if (!tables_valid_q) begin
			status = ST_NOT_BUILT;
		end else begin
			case (op_q)
				OP_ANTILOG: begin
					if (32'(expo_q) >= 32'(mask)) begin
						status = ST_STEP_RANGE;
					end else begin
						element_out = ELEM_W'(al_rd_q);
					end
				end
				OP_LOG: begin
					log_out = elem_zero ? LOG_ZERO : LOG_W'(lg_rd_q);
				end
				OP_POWER: begin
					if (!elem_zero) begin
						element_out = ELEM_W'(al_rd_q);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/gfel_checker.sv @@
// ----------------------------------------------------------------------------
// gfel_checker
// Port-level checks on the item sequencing and result fields.
// ----------------------------------------------------------------------------
module gfel_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic [gfel_pkg::ELEM_W-1:0]       element_out,
	input logic signed [gfel_pkg::LOG_W-1:0] log_out,
	input logic [gfel_pkg::STATUS_W-1:0]     status
);
	import gfel_pkg::*;

	// an accepted item keeps the block busy until its result
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("item accepted but block not busy");

	// a result ends the item: back to idle straight after
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy && !done))
		else $error("block still busy after result");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while idle");

	a_not_built_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_NOT_BUILT) |-> (element_out == '0 && log_out == '0))
		else $error("not-built result carries data");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_STEP_RANGE) |-> (element_out == '0 && log_out == '0))
		else $error("out-of-range step carries data");

endmodule

bind gf2m_exp_log_table_engine gfel_checker u_gfel_checker (.*);

@@ verif/gf2m_exp_log_table_engine_chk.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gf2m_exp_log_table_engine_chk
// Scoreboard for the GF(2^m) table engine. Keeps its own copy of the field
// registers and of both power tables, works out the answer to each item the
// engine takes and compares it, field by field, with the next done strobe.
// ----------------------------------------------------------------------------
module gf2m_exp_log_table_engine_chk #(
	parameter int MAX_DEG = gfel_pkg::MAX_DEGREE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [gfel_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gfel_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              start,
	input  logic                              busy,
	input  logic [gfel_pkg::OP_W-1:0]         op,
	input  logic [gfel_pkg::EXP_W-1:0]        exponent,
	input  logic [gfel_pkg::ELEM_W-1:0]       element,
	input  logic                              done,
	input  logic [gfel_pkg::ELEM_W-1:0]       element_out,
	input  logic signed [gfel_pkg::LOG_W-1:0] log_out,
	input  logic [gfel_pkg::STATUS_W-1:0]     status,
	output int                                mismatches,
	output int                                in_flight
);
	import gfel_pkg::*;

	typedef struct packed {
		logic [OP_W-1:0]     opc;
		logic [ELEM_W-1:0]   elem;
		logic [LOG_W-1:0]    lg;
		logic [STATUS_W-1:0] st;
	} answer_t;

	logic [ELEM_W-1:0] power_of_alpha [0:255];
	logic [ELEM_W-1:0] log_of_elem [0:255];
	logic              built;
	logic [DEG_W-1:0]  degree_reg;
	logic [POLY_W-1:0] poly_reg;
	answer_t           awaited[$];
	answer_t           want;
	answer_t           got;
	int                errs;

	task automatic report_mismatch(input string what);
		errs++;
		$display("%0t ns: %s", $time, what);
	endtask

	// build walks alpha^i by multiply-by-x; lookups read the mirrored tables
	task automatic field_answer(input op_t opc, input logic [EXP_W-1:0] expo,
			input logic [ELEM_W-1:0] elem_in, output answer_t a);
		int unsigned m, q, poly, cur, e, lg, s, i;
		logic        hi;
		m = 32'(degree_reg);
		if (m < 2)
			m = 2;
		if (m > MAX_DEG)
			m = MAX_DEG;
		q = 1 << m;
		e = elem_in & (q - 1);
		a = '0;
		a.opc = opc;
		a.st = ST_OK;
		if (opc == OP_BUILD) begin
			poly = poly_reg & (q - 1);
			cur = 1;
			for (i = 0; i < q - 1; i++) begin
				power_of_alpha[i] = cur[7:0];
				log_of_elem[cur] = i[7:0];
				hi = cur[m-1];
				cur = (cur << 1) & (q - 1);
				if (hi)
					cur = cur ^ poly;
			end
			built = (cur == 1);
			a.st = built ? ST_OK : ST_NOT_PRIMITIVE;
		end else if (!built) begin
			a.st = ST_NOT_BUILT;
		end else begin
			case (opc)
				OP_ANTILOG: begin
					if (expo >= q - 1)
						a.st = ST_STEP_RANGE;
					else
						a.elem = power_of_alpha[expo];
				end
				OP_LOG: begin
					a.lg = (e == 0) ? LOG_ZERO : {1'b0, log_of_elem[e]};
				end
				default: begin
					// zero to any power, power 0 included, stays zero
					if (e != 0) begin
						lg = 32'(log_of_elem[e]);
						s = (lg * expo) % (q - 1);
						a.elem = power_of_alpha[s];
					end
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_reg = DEGREE_RESET;
			poly_reg = POLY_RESET;
			built = 1'b0;
			awaited.delete();
			in_flight <= 0;
		end else begin
			if (done) begin
				if (awaited.size() == 0) begin
					report_mismatch($sformatf("result with nothing awaited: elem %0h log %0h st %0d",
						element_out, log_out, status));
				end else begin
					want = awaited.pop_front();
					if (element_out !== want.elem)
						report_mismatch($sformatf("op %0d element_out %0h, predicted %0h",
							want.opc, element_out, want.elem));
					if (log_out !== want.lg)
						report_mismatch($sformatf("op %0d log_out %0h, predicted %0h",
							want.opc, log_out, want.lg));
					if (status !== want.st)
						report_mismatch($sformatf("op %0d status %0d, predicted %0d",
							want.opc, status, want.st));
				end
			end
			// any register write drops the tables
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DEGREE)
					degree_reg = cfg_data[DEG_W-1:0];
				else if (cfg_index == REG_POLY)
					poly_reg = cfg_data;
				built = 1'b0;
			end
			if (start && !busy) begin
				field_answer(op_t'(op), exponent, element, got);
				awaited.push_back(got);
			end
			in_flight <= awaited.size();
		end
		mismatches <= errs;
	end

endmodule

@@ verif/gf2m_exp_log_table_engine_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gf2m_exp_log_table_engine_tb
// Regression for the GF(2^m) table engine. A directed run covers the not
// built, out of range, zero element and wrap cases; then random phases over
// several field settings build the tables and hammer the lookups, with the
// sender idling at different rates. The checker does the predicting.
// ----------------------------------------------------------------------------
module gf2m_exp_log_table_engine_tb;
	import gfel_pkg::*;

	localparam logic [1:0] WR_DEG  = 2'b01;
	localparam logic [1:0] WR_POLY = 2'b10;
	localparam logic [1:0] WR_BOTH = 2'b11;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    start = 1'b0;
	logic [OP_W-1:0]         op = '0;
	logic [EXP_W-1:0]        exponent = '0;
	logic [ELEM_W-1:0]       element = '0;
	logic                    cfg_ready;
	logic                    busy;
	logic                    done;
	logic [ELEM_W-1:0]       element_out;
	logic signed [LOG_W-1:0] log_out;
	logic [STATUS_W-1:0]     status;
	int                      mismatches;
	int                      in_flight;
	int unsigned             idle_pct = 0;
	logic [DEG_W-1:0]        deg_now = DEGREE_RESET;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	gf2m_exp_log_table_engine dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.op(op), .exponent(exponent), .element(element),
		.done(done), .element_out(element_out), .log_out(log_out), .status(status)
	);

	gf2m_exp_log_table_engine_chk chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.op(op), .exponent(exponent), .element(element),
		.done(done), .element_out(element_out), .log_out(log_out), .status(status),
		.mismatches(mismatches), .in_flight(in_flight)
	);

	// start stays high when the next item follows straight on
	task automatic send_item(input op_t o, input logic [EXP_W-1:0] x,
			input logic [ELEM_W-1:0] el);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		exponent <= x;
		element <= el;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic program_field(input logic [1:0] which, input logic [7:0] deg_data,
			input logic [7:0] poly_data);
		int k;
		for (k = 0; k < 2; k++) begin
			if (which[k]) begin
				cfg_valid <= 1'b1;
				cfg_index <= (k == 0) ? REG_DEGREE : REG_POLY;
				cfg_data <= (k == 0) ? deg_data : poly_data;
				if (k == 0)
					deg_now = deg_data[DEG_W-1:0];
				do @(posedge clk); while (!cfg_ready);
			end
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned m, q, r, n, ph;
		logic [7:0]  d, p;
		logic [1:0]  which;
		logic [15:0] x;
		logic [7:0]  el;
		op_t         o;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing built yet
		send_item(OP_ANTILOG, 16'd0, 8'h00);
		send_item(OP_LOG, 16'd0, 8'h05);
		send_item(OP_POWER, 16'd3, 8'h02);
		// reset field: degree 8, x^8+x^4+x^3+x^2+1
		send_item(OP_BUILD, 16'hFFFF, 8'hFF);
		send_item(OP_ANTILOG, 16'd0, 8'h00);
		send_item(OP_ANTILOG, 16'd254, 8'h00);
		send_item(OP_ANTILOG, 16'd255, 8'h00);
		send_item(OP_LOG, 16'hFFFF, 8'h00);
		send_item(OP_LOG, 16'd0, 8'h01);
		send_item(OP_LOG, 16'd0, 8'hFF);
		send_item(OP_POWER, 16'd0, 8'h00);
		send_item(OP_POWER, 16'hFFFF, 8'h00);
		send_item(OP_POWER, 16'd0, 8'h02);
		send_item(OP_POWER, 16'hFFFF, 8'hFF);
		send_item(OP_POWER, 16'hAAAA, 8'h80);
		// degree 3, poly bits above m dropped; elements wrap
		wait_idle();
		program_field(WR_DEG, 8'h03, 8'h00);
		send_item(OP_LOG, 16'd0, 8'h01);
		send_item(OP_BUILD, 16'd0, 8'h00);
		send_item(OP_LOG, 16'd0, 8'hF9);
		send_item(OP_POWER, 16'hFFFF, 8'hFE);
		// x^3 alone never returns to 1
		wait_idle();
		program_field(WR_POLY, 8'h00, 8'h00);
		send_item(OP_BUILD, 16'd0, 8'h00);
		send_item(OP_ANTILOG, 16'd1, 8'h00);
		// degree 0 acts as 2
		wait_idle();
		program_field(WR_BOTH, 8'h00, 8'hFF);
		send_item(OP_BUILD, 16'd0, 8'h00);
		send_item(OP_ANTILOG, 16'd2, 8'h00);
		send_item(OP_ANTILOG, 16'd3, 8'h00);

		for (ph = 0; ph < 12; ph++) begin
			case (ph)
				0: begin d = 8'h02; p = 8'h03; end
				1: begin d = 8'hF8; p = 8'h1D; end
				2: begin d = 8'h0F; p = 8'h2B; end
				3: begin d = 8'h01; p = 8'h03; end
				4: begin d = 8'h04; p = 8'hF3; end
				5: begin d = 8'h05; p = 8'h05; end
				6: begin d = 8'h06; p = 8'h03; end
				7: begin d = 8'h07; p = 8'h09; end
				8: begin d = 8'h08; p = 8'h1B; end
				default: begin d = 8'($urandom); p = 8'($urandom); end
			endcase
			which = (ph < 2) ? WR_BOTH : 2'($urandom_range(1, 3));
			case (ph % 3)
				0: idle_pct = 0;
				1: idle_pct = 57;
				default: idle_pct = 36;
			endcase
			wait_idle();
			program_field(which, d, p);
			m = 32'(deg_now);
			if (m < 2)
				m = 2;
			if (m > MAX_DEGREE_DEF)
				m = MAX_DEGREE_DEF;
			q = 1 << m;
			// now and then leave the tables unbuilt
			if ($urandom_range(7) != 0)
				send_item(OP_BUILD, 16'($urandom), 8'($urandom));
			for (n = 0; n < 50; n++) begin
				r = $urandom_range(99);
				el = 8'($urandom);
				if ($urandom_range(9) == 0)
					el = 8'h00;
				x = 16'($urandom);
				if (r < 4) begin
					o = OP_BUILD;
				end else if (r < 34) begin
					o = OP_ANTILOG;
					case ($urandom_range(9))
						0: x = 16'(q - 1);
						1: x = 16'(q - 2);
						2: ;
						default: x = 16'($urandom_range(q - 2));
					endcase
				end else if (r < 64) begin
					o = OP_LOG;
				end else begin
					o = OP_POWER;
					case ($urandom_range(9))
						0: x = 16'd0;
						1: x = 16'hFFFF;
						2: x = 16'((q - 1) * $urandom_range(200));
						default: ;
					endcase
				end
				send_item(o, x, el);
			end
		end

		wait_idle();
		repeat (300) @(posedge clk);
		if (mismatches == 0 && in_flight == 0)
			$display("gf2m_exp_log_table_engine regression: pass");
		else
			$display("gf2m_exp_log_table_engine regression: fail");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("gf2m_exp_log_table_engine regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/gfel_pkg.sv
rtl/gfel_ctrl.sv
rtl/gfel_dp.sv
rtl/gf2m_exp_log_table_engine.sv
rtl/gfel_checker.sv
verif/gf2m_exp_log_table_engine_chk.sv
verif/gf2m_exp_log_table_engine_tb.sv
